/* design/tcpu_pkg.sv */
// ----------------------------------------------------------------------------
// tcpu_pkg: shared types and codes for the tiny 16-bit machine
// Host operation codes, instruction codes, status codes and the command and
// status bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package tcpu_pkg;

	localparam int ADDR_W = 16;
	localparam int WORD_W = 16;
	localparam int BYTE_W = 8;
	localparam int OP_W   = 3;
	localparam int ST_W   = 2;
	localparam int NIB_W  = 4;

	// Host operation codes carried with each input item.
	localparam logic [OP_W-1:0] HOP_STEP    = 3'd0;
	localparam logic [OP_W-1:0] HOP_MEM_WR  = 3'd1;
	localparam logic [OP_W-1:0] HOP_MEM_RD  = 3'd2;
	localparam logic [OP_W-1:0] HOP_REG_RD  = 3'd3;
	localparam logic [OP_W-1:0] HOP_RESTART = 3'd4;

	// Instruction codes held in memory.
	localparam logic [BYTE_W-1:0] INS_MOV_LAST = 8'd6;
	localparam logic [BYTE_W-1:0] INS_STR      = 8'd7;
	localparam logic [BYTE_W-1:0] INS_LDR      = 8'd8;
	localparam logic [BYTE_W-1:0] INS_JMP      = 8'd9;

	typedef logic [ST_W-1:0] status_t;

	localparam status_t ST_OK      = 2'd0;
	localparam status_t ST_UNKNOWN = 2'd1;
	localparam status_t ST_BADREG  = 2'd2;
	localparam status_t ST_HALTED  = 2'd3;

	typedef enum logic [1:0] {RD_PC, RD_HOST, RD_EA, RD_EA1} mem_rd_sel_t;
	typedef enum logic [1:0] {WR_HOST, WR_EA_LO, WR_EA1_HI} mem_wr_sel_t;
	typedef enum logic [1:0] {RS_HOST, RS_AR, RS_DR} reg_sel_t;
	typedef enum logic [1:0] {RV_ZERO, RV_MEM, RV_REG} rv_sel_t;
	typedef enum logic [2:0] {K_MOV, K_STR, K_LDR, K_JMP, K_BAD} ins_kind_t;

	typedef struct packed {
		logic        capture;
		logic        mem_rd_en;
		mem_rd_sel_t mem_rd_sel;
		logic        mem_wr_en;
		mem_wr_sel_t mem_wr_sel;
		logic        pc_inc;
		logic        pc_jmp;
		logic        pc_entry;
		logic        instr_load;
		logic        lo_load;
		logic        pair_load;
		reg_sel_t    reg_rd_sel;
		logic        ea_load;
		logic        val_load;
		logic        reg_wr_en;
		logic        reg_wr_ldr;
		logic        regs_clear;
		logic        halt_set;
		logic        halt_clear;
		logic        res_load;
		status_t     st;
		rv_sel_t     rv_sel;
	} tcpu_cmd_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            halted;
		logic            host_reg_ok;
		logic            pair_ok;
		ins_kind_t       kind;
	} tcpu_stat_t;

endpackage

/* design/tcpu_dpath.sv */
// ----------------------------------------------------------------------------
// tcpu_dpath: datapath of the tiny 16-bit machine
// Byte memory, register file, program counter, halt flag, operand registers
// and the result register, all driven by commands from the controller.
// ----------------------------------------------------------------------------
module tcpu_dpath
	import tcpu_pkg::*;
#(
	parameter int MEM_ADDR_BITS = 16,
	parameter int NUM_REGS      = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [WORD_W-1:0] cfg_wr_data,
	input  logic [OP_W-1:0]   in_opcode,
	input  logic [ADDR_W-1:0] in_host_address,
	input  logic [BYTE_W-1:0] in_host_data,
	input  tcpu_cmd_t         cmd,
	output tcpu_stat_t        stat,
	output logic [WORD_W-1:0] pc_now,
	output logic [WORD_W-1:0] read_value,
	output status_t           status
);

	localparam int RIW      = $clog2(NUM_REGS);
	localparam int MEM_SIZE = 1 << MEM_ADDR_BITS;

	logic [BYTE_W-1:0]        mem [MEM_SIZE];
	logic [WORD_W-1:0]        regs_q [NUM_REGS];
	logic [WORD_W-1:0]        pc_q;
	logic [WORD_W-1:0]        entry_q;
	logic                     halted_q;
	logic [OP_W-1:0]          op_q;
	logic [ADDR_W-1:0]        haddr_q;
	logic [BYTE_W-1:0]        hdata_q;
	logic [BYTE_W-1:0]        instr_q;
	logic [BYTE_W-1:0]        byte_q;
	logic [BYTE_W-1:0]        pair_q;
	logic [ADDR_W-1:0]        ea_q;
	logic [WORD_W-1:0]        val_q;
	logic [BYTE_W-1:0]        mem_rd_q;
	logic [WORD_W-1:0]        res_pc_q;
	logic [WORD_W-1:0]        res_rv_q;
	status_t                  res_st_q;
	logic [ADDR_W-1:0]        ea1;
	logic [ADDR_W-1:0]        rd_addr;
	logic [ADDR_W-1:0]        wr_addr;
	logic [BYTE_W-1:0]        wr_data;
	logic [RIW-1:0]           rd_idx;
	logic [RIW-1:0]           wr_idx;
	logic [WORD_W-1:0]        reg_rd;
	logic [WORD_W-1:0]        rv;
	logic [WORD_W-1:0]        word_in;
	ins_kind_t                kind;

	assign ea1     = ea_q + 16'd1;
	assign word_in = {mem_rd_q, byte_q};

	always_comb begin
		case (cmd.mem_rd_sel)
			RD_PC:   rd_addr = pc_q;
			RD_HOST: rd_addr = haddr_q;
			RD_EA:   rd_addr = ea_q;
			RD_EA1:  rd_addr = ea1;
			default: rd_addr = pc_q;
		endcase
	end

	always_comb begin
		case (cmd.mem_wr_sel)
			WR_HOST: begin
				wr_addr = haddr_q;
				wr_data = hdata_q;
			end
			WR_EA_LO: begin
				wr_addr = ea_q;
				wr_data = val_q[BYTE_W-1:0];
			end
			WR_EA1_HI: begin
				wr_addr = ea1;
				wr_data = val_q[WORD_W-1:BYTE_W];
			end
			default: begin
				wr_addr = haddr_q;
				wr_data = hdata_q;
			end
		endcase
	end

	// Byte memory: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (cmd.mem_wr_en) begin
			mem[wr_addr[MEM_ADDR_BITS-1:0]] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mem_rd_en) begin
			mem_rd_q <= mem[rd_addr[MEM_ADDR_BITS-1:0]];
		end
	end

	always_comb begin
		case (cmd.reg_rd_sel)
			RS_HOST: rd_idx = haddr_q[RIW-1:0];
			RS_AR:   rd_idx = pair_q[NIB_W+RIW-1:NIB_W];
			RS_DR:   rd_idx = pair_q[RIW-1:0];
			default: rd_idx = haddr_q[RIW-1:0];
		endcase
	end

	assign reg_rd = (int'(rd_idx) < NUM_REGS) ? regs_q[rd_idx] : '0;
	assign wr_idx = cmd.reg_wr_ldr ? pair_q[RIW-1:0] : instr_q[RIW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				regs_q[i] <= '0;
			end
		end else if (cmd.regs_clear) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				regs_q[i] <= '0;
			end
		end else if (cmd.reg_wr_en) begin
			regs_q[wr_idx] <= word_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q     <= '0;
			entry_q  <= '0;
			halted_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				entry_q <= cfg_wr_data;
			end
			if (cmd.pc_entry) begin
				pc_q <= entry_q;
			end else if (cmd.pc_jmp) begin
				pc_q <= word_in;
			end else if (cmd.pc_inc) begin
				pc_q <= pc_q + 16'd1;
			end
			if (cmd.halt_clear) begin
				halted_q <= 1'b0;
			end else if (cmd.halt_set) begin
				halted_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q    <= in_opcode;
			haddr_q <= in_host_address;
			hdata_q <= in_host_data;
		end
		if (cmd.instr_load) begin
			instr_q <= mem_rd_q;
		end
		if (cmd.lo_load) begin
			byte_q <= mem_rd_q;
		end
		if (cmd.pair_load) begin
			pair_q <= mem_rd_q;
		end
		if (cmd.ea_load) begin
			ea_q <= reg_rd;
		end
		if (cmd.val_load) begin
			val_q <= reg_rd;
		end
	end

	always_comb begin
		case (cmd.rv_sel)
			RV_ZERO: rv = '0;
			RV_MEM:  rv = {{(WORD_W-BYTE_W){1'b0}}, mem_rd_q};
			RV_REG:  rv = reg_rd;
			default: rv = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			res_pc_q <= pc_q;
			res_rv_q <= rv;
			res_st_q <= cmd.st;
		end
	end

	assign pc_now     = res_pc_q;
	assign read_value = res_rv_q;
	assign status     = res_st_q;

	// Decode of the byte just read, used when it is an instruction code.
	always_comb begin
		if (mem_rd_q <= INS_MOV_LAST) begin
			kind = K_MOV;
		end else if (mem_rd_q == INS_STR) begin
			kind = K_STR;
		end else if (mem_rd_q == INS_LDR) begin
			kind = K_LDR;
		end else if (mem_rd_q == INS_JMP) begin
			kind = K_JMP;
		end else begin
			kind = K_BAD;
		end
	end

	assign stat.kind        = kind;
	assign stat.op          = op_q;
	assign stat.halted      = halted_q;
	assign stat.host_reg_ok = int'(haddr_q) < NUM_REGS;
	assign stat.pair_ok     = (int'(mem_rd_q[BYTE_W-1:NIB_W]) < NUM_REGS)
		&& (int'(mem_rd_q[NIB_W-1:0]) < NUM_REGS);

endmodule

/* design/tcpu_ctrl.sv */
// ----------------------------------------------------------------------------
// tcpu_ctrl: controller of the tiny 16-bit machine
// Sequences host accesses and the fetch, decode and execute steps of one
// instruction, and owns the input and output handshakes.
// ----------------------------------------------------------------------------
module tcpu_ctrl
	import tcpu_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  tcpu_stat_t stat,
	output tcpu_cmd_t  cmd
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_DISP = 4'd1;
	localparam logic [3:0] S_F1   = 4'd2;
	localparam logic [3:0] S_F2   = 4'd3;
	localparam logic [3:0] S_F3   = 4'd4;
	localparam logic [3:0] S_AREG = 4'd5;
	localparam logic [3:0] S_DREG = 4'd6;
	localparam logic [3:0] S_W0   = 4'd7;
	localparam logic [3:0] S_W1   = 4'd8;
	localparam logic [3:0] S_L0   = 4'd9;
	localparam logic [3:0] S_L1   = 4'd10;
	localparam logic [3:0] S_L2   = 4'd11;
	localparam logic [3:0] S_DONE = 4'd12;

	logic [3:0] state_q, state_d;
	ins_kind_t  kind_q, kind_d;
	status_t    st_q, st_d;
	rv_sel_t    rvsel_q, rvsel_d;
	logic       out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd            = '0;
		cmd.mem_rd_sel = RD_PC;
		cmd.mem_wr_sel = WR_HOST;
		cmd.reg_rd_sel = RS_HOST;
		cmd.st         = st_q;
		cmd.rv_sel     = rvsel_q;
		state_d        = state_q;
		kind_d         = kind_q;
		st_d           = st_q;
		rvsel_d        = rvsel_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_DISP;
				end
			end
			S_DISP: begin
				rvsel_d = RV_ZERO;
				st_d    = stat.halted ? ST_HALTED : ST_OK;
				state_d = S_DONE;
				case (stat.op)
					HOP_STEP: begin
						if (!stat.halted) begin
							cmd.mem_rd_en  = 1'b1;
							cmd.mem_rd_sel = RD_PC;
							cmd.pc_inc     = 1'b1;
							state_d        = S_F1;
						end
					end
					HOP_MEM_WR: begin
						cmd.mem_wr_en  = 1'b1;
						cmd.mem_wr_sel = WR_HOST;
					end
					HOP_MEM_RD: begin
						cmd.mem_rd_en  = 1'b1;
						cmd.mem_rd_sel = RD_HOST;
						rvsel_d        = RV_MEM;
					end
					HOP_REG_RD: begin
						if (stat.host_reg_ok) begin
							rvsel_d = RV_REG;
						end else if (!stat.halted) begin
							st_d = ST_BADREG;
						end
					end
					HOP_RESTART: begin
						cmd.pc_entry   = 1'b1;
						cmd.regs_clear = 1'b1;
						cmd.halt_clear = 1'b1;
						st_d           = ST_OK;
					end
					default: begin
						st_d = ST_UNKNOWN;
					end
				endcase
			end
			S_F1: begin
				cmd.instr_load = 1'b1;
				kind_d         = stat.kind;
				if (stat.kind == K_BAD) begin
					cmd.halt_set = 1'b1;
					st_d         = ST_UNKNOWN;
					state_d      = S_DONE;
				end else begin
					cmd.mem_rd_en  = 1'b1;
					cmd.mem_rd_sel = RD_PC;
					cmd.pc_inc     = 1'b1;
					state_d        = S_F2;
				end
			end
			S_F2: begin
				case (kind_q)
					K_MOV, K_JMP: begin
						cmd.lo_load    = 1'b1;
						cmd.mem_rd_en  = 1'b1;
						cmd.mem_rd_sel = RD_PC;
						cmd.pc_inc     = 1'b1;
						state_d        = S_F3;
					end
					K_STR, K_LDR: begin
						cmd.pair_load = 1'b1;
						if (stat.pair_ok) begin
							state_d = S_AREG;
						end else begin
							cmd.halt_set = 1'b1;
							st_d         = ST_BADREG;
							state_d      = S_DONE;
						end
					end
					default: begin
						state_d = S_DONE;
					end
				endcase
			end
			S_F3: begin
				if (kind_q == K_JMP) begin
					cmd.pc_jmp = 1'b1;
				end else begin
					cmd.reg_wr_en = 1'b1;
				end
				state_d = S_DONE;
			end
			S_AREG: begin
				cmd.reg_rd_sel = RS_AR;
				cmd.ea_load    = 1'b1;
				state_d        = (kind_q == K_STR) ? S_DREG : S_L0;
			end
			S_DREG: begin
				cmd.reg_rd_sel = RS_DR;
				cmd.val_load   = 1'b1;
				state_d        = S_W0;
			end
			S_W0: begin
				cmd.mem_wr_en  = 1'b1;
				cmd.mem_wr_sel = WR_EA_LO;
				state_d        = S_W1;
			end
			S_W1: begin
				cmd.mem_wr_en  = 1'b1;
				cmd.mem_wr_sel = WR_EA1_HI;
				state_d        = S_DONE;
			end
			S_L0: begin
				cmd.mem_rd_en  = 1'b1;
				cmd.mem_rd_sel = RD_EA;
				state_d        = S_L1;
			end
			S_L1: begin
				cmd.lo_load    = 1'b1;
				cmd.mem_rd_en  = 1'b1;
				cmd.mem_rd_sel = RD_EA1;
				state_d        = S_L2;
			end
			S_L2: begin
				cmd.reg_wr_en  = 1'b1;
				cmd.reg_wr_ldr = 1'b1;
				state_d        = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.res_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			kind_q      <= K_MOV;
			st_q        <= ST_OK;
			rvsel_q     <= RV_ZERO;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			kind_q  <= kind_d;
			st_q    <= st_d;
			rvsel_q <= rvsel_d;
			if (cmd.res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_accept_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_DISP))
		else $error("accepted item did not move to dispatch");

	a_result_shown: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |=> out_valid_q)
		else $error("loaded result not presented");

	a_no_fetch_halted: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pc_inc |-> !stat.halted)
		else $error("program counter advanced while halted");

	a_write_states: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mem_wr_en |-> (state_q == S_DISP || state_q == S_W0 || state_q == S_W1))
		else $error("memory written outside a write state");

endmodule

/* design/tiny_cpu_instruction_step.sv */
// ----------------------------------------------------------------------------
// tiny_cpu_instruction_step: tiny 16-bit machine, one host item at a time
// A controller sequences a datapath holding a byte memory, a register file,
// a program counter and a halt flag. Each item either steps one instruction
// or performs a host access, and returns one result item.
// ----------------------------------------------------------------------------
//
// Channel     Direction  Handshake                     Contents
// s_axis      in         s_axis_tvalid/s_axis_tready   tuser opcode, tdata address and data
// m_axis      out        m_axis_tvalid/m_axis_tready   tdata pc_now, read_value, status
// cfg         in         cfg_wr_en                     cfg_wr_data entry point
//
// Host accesses go straight to memory or the register file. A step fetches
// its instruction bytes and moves its data bytes through the byte-wide
// memory one byte at a time before the result is presented, and a step that
// faults ends early. Reset clears the registers, program counter and halt
// flag; memory holds whatever it held. A new item is taken while the
// previous result waits in the output register; a stall on the output side
// only holds the block in its final state until that register is free.
// ----------------------------------------------------------------------------
module tiny_cpu_instruction_step
	import tcpu_pkg::*;
#(
	parameter int MEM_ADDR_BITS = 16,
	parameter int NUM_REGS      = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	// Configuration: entry point loaded into the program counter on restart.
	input  logic              cfg_wr_en,
	input  logic [WORD_W-1:0] cfg_wr_data,
	// Input items.
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [23:0]       s_axis_tdata,  // [15:0] host_address, [23:16] host_data
	input  logic [OP_W-1:0]   s_axis_tuser,  // [2:0] opcode
	// Result items.
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [39:0]       m_axis_tdata   // [15:0] pc_now, [31:16] read_value,
	                                         // [33:32] status, [39:34] zero
);

	tcpu_cmd_t         cmd;
	tcpu_stat_t        stat;
	logic [WORD_W-1:0] pc_now;
	logic [WORD_W-1:0] read_value;
	status_t           status;

	// The controller decides every transfer; the datapath only obeys.
	tcpu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	tcpu_dpath #(
		.MEM_ADDR_BITS (MEM_ADDR_BITS),
		.NUM_REGS      (NUM_REGS)
	) u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.in_opcode       (s_axis_tuser),
		.in_host_address (s_axis_tdata[15:0]),
		.in_host_data    (s_axis_tdata[23:16]),
		.cmd             (cmd),
		.stat            (stat),
		.pc_now          (pc_now),
		.read_value      (read_value),
		.status          (status)
	);

	// Result fields packed from the lowest bit up, padded to whole bytes.
	assign m_axis_tdata = {6'b0, status, read_value, pc_now};

endmodule
